[rtl/core/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg: shared types and constants of the UTF-8 decoder
// Control/status records between controller and datapath, UTF-8 constants
// and the sequence length decode of a lead byte.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned DEPTH   = 4;
    localparam int unsigned IDX_W   = 2;

    localparam logic [BYTE_W-1:0] MASK_E0 = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_C0 = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_F0 = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_F8 = 8'hF8;
    localparam logic [BYTE_W-1:0] CONT_80 = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_E0 = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_F0 = 8'hF0;

    localparam logic [CP_W-1:0] REPL_CHAR = 21'h00003F;
    localparam logic [CP_W-1:0] MIN_2B    = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3B    = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4B    = 21'h010000;
    localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;

    typedef struct packed {
        logic accept;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic has_result;
        logic last;
        logic out_valid;
    } t_status;

    // 0 means a bad lead byte
    function automatic logic [CNT_W-1:0] seq_len(input logic [BYTE_W-1:0] c0);
        logic [CNT_W-1:0] len;
        if (c0 < CONT_80) begin
            len = 3'd1;
        end else if ((c0 & MASK_E0) == MASK_C0) begin
            len = 3'd2;
        end else if ((c0 & MASK_F0) == LEAD_E0) begin
            len = 3'd3;
        end else if ((c0 & MASK_F8) == LEAD_F0) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

endpackage

[rtl/core/utf8d_if.sv]
// ----------------------------------------------------------------------------
// utf8d_if: stream channels of the UTF-8 decoder
// Byte input channel and code point output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface utf8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       string_end;

    modport source (output valid, output data_byte, output string_end, input ready);
    modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

interface utf8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        replaced;
    logic        burst_last;
    logic        string_last;
    logic        string_ok;

    modport source (output valid, output code_point, output replaced, output burst_last,
                    output string_last, output string_ok, input ready);
    modport sink   (input valid, input code_point, input replaced, input burst_last,
                    input string_last, input string_ok, output ready);
endinterface

[rtl/core/utf8d_ctrl.sv]
// ----------------------------------------------------------------------------
// utf8d_ctrl: decoder sequencer
// Takes a byte word, then steps the datapath once per result until the held
// bytes are used up or wait for more input.
// ----------------------------------------------------------------------------
module utf8d_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    input  utf8d_pkg::t_status i_status,
    output utf8d_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.step = !i_status.out_valid || i_out_ready;
                if (o_cmd.step && (!i_status.has_result || i_status.last)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/utf8d_dpath.sv]
// ----------------------------------------------------------------------------
// utf8d_dpath: decoder datapath
// Holds the bytes of an unfinished sequence, decodes the front sequence,
// shifts out the bytes it used and registers the result word.
// ----------------------------------------------------------------------------
module utf8d_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  utf8d_pkg::t_cmd    i_cmd,
    output utf8d_pkg::t_status o_status,
    input  logic [7:0]         i_data_byte,
    input  logic               i_string_end,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [20:0]        o_code_point,
    output logic               o_replaced,
    output logic               o_burst_last,
    output logic               o_string_last,
    output logic               o_string_ok
);

    logic [7:0]  r_buf [utf8d_pkg::DEPTH];
    logic [7:0]  n_buf [utf8d_pkg::DEPTH];
    logic [2:0]  r_cnt;
    logic [2:0]  n_cnt;
    logic        r_end;
    logic        r_all_valid;
    logic        r_out_valid;
    logic [20:0] r_cp;
    logic        r_repl;
    logic        r_blast;
    logic        r_slast;
    logic        r_sok;

    logic [1:0]  app_idx;
    logic [2:0]  need;
    logic [2:0]  need_nx;
    logic [2:0]  drop;
    logic        conts_ok;
    logic        has_res;
    logic        repl;
    logic        last;
    logic [20:0] cp;
    logic [20:0] cp2;
    logic [20:0] cp3;
    logic [20:0] cp4;

    assign app_idx = (r_cnt > 3'd3) ? 2'd3 : r_cnt[1:0];
    assign need    = utf8d_pkg::seq_len(r_buf[0]);

    always_comb begin
        conts_ok = 1'b1;
        for (int i = 1; i < utf8d_pkg::DEPTH; i++) begin
            if ((3'(i) < need) && ((r_buf[i] & utf8d_pkg::MASK_C0) != utf8d_pkg::CONT_80)) begin
                conts_ok = 1'b0;
            end
        end
    end

    assign cp2 = {10'd0, r_buf[0][4:0], r_buf[1][5:0]};
    assign cp3 = {5'd0, r_buf[0][3:0], r_buf[1][5:0], r_buf[2][5:0]};
    assign cp4 = {r_buf[0][2:0], r_buf[1][5:0], r_buf[2][5:0], r_buf[3][5:0]};

    always_comb begin
        has_res = 1'b1;
        repl    = 1'b1;
        cp      = utf8d_pkg::REPL_CHAR;
        drop    = 3'd1;
        if (need == 3'd0) begin
            drop = 3'd1;
        end else if (r_cnt < need) begin
            has_res = r_end;
            drop    = r_cnt;
        end else if (!conts_ok) begin
            drop = 3'd1;
        end else begin
            drop = need;
            unique case (need)
                3'd1: begin
                    cp   = {13'd0, r_buf[0]};
                    repl = 1'b0;
                end
                3'd2: begin
                    repl = cp2 < utf8d_pkg::MIN_2B;
                    cp   = repl ? utf8d_pkg::REPL_CHAR : cp2;
                end
                3'd3: begin
                    repl = cp3 < utf8d_pkg::MIN_3B;
                    cp   = repl ? utf8d_pkg::REPL_CHAR : cp3;
                end
                default: begin
                    repl = (cp4 < utf8d_pkg::MIN_4B) || (cp4 > utf8d_pkg::MAX_CP);
                    cp   = repl ? utf8d_pkg::REPL_CHAR : cp4;
                end
            endcase
        end
    end

    // bytes left after this result, and whether they yield another result now
    always_comb begin
        n_cnt = (drop >= r_cnt) ? 3'd0 : (r_cnt - drop);
        for (int i = 0; i < utf8d_pkg::DEPTH; i++) begin
            n_buf[i] = r_buf[i];
        end
        unique case (drop)
            3'd1: begin
                n_buf[0] = r_buf[1];
                n_buf[1] = r_buf[2];
                n_buf[2] = r_buf[3];
            end
            3'd2: begin
                n_buf[0] = r_buf[2];
                n_buf[1] = r_buf[3];
            end
            3'd3: begin
                n_buf[0] = r_buf[3];
            end
            default: begin
            end
        endcase
    end

    assign need_nx = utf8d_pkg::seq_len(n_buf[0]);
    assign last    = (n_cnt == 3'd0) || ((need_nx != 3'd0) && (n_cnt < need_nx) && !r_end);

    assign o_status.has_result = has_res;
    assign o_status.last       = last;
    assign o_status.out_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 3'd0;
            r_all_valid <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_buf[app_idx] <= i_data_byte;
                r_cnt          <= {1'b0, app_idx} + 3'd1;
                r_end          <= i_string_end;
            end else if (i_cmd.step && has_res) begin
                r_buf <= n_buf;
                r_cnt <= n_cnt;
                if (last && r_end) begin
                    r_all_valid <= 1'b1;
                end else if (repl) begin
                    r_all_valid <= 1'b0;
                end
            end
            if (i_cmd.step && has_res) begin
                r_out_valid <= 1'b1;
                r_cp        <= cp;
                r_repl      <= repl;
                r_blast     <= last;
                r_slast     <= last && r_end;
                r_sok       <= last && r_end && r_all_valid && !repl;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_code_point  = r_cp;
    assign o_replaced    = r_repl;
    assign o_burst_last  = r_blast;
    assign o_string_last = r_slast;
    assign o_string_ok   = r_sok;

endmodule

[rtl/core/utf8_to_utf32_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder: UTF-8 byte stream to UTF-32 code points
// Top level: sequencer plus datapath, stream channels on both sides.
// ----------------------------------------------------------------------------
// One byte word is taken at a time; the decoder then steps once per result
// it produces, and a byte that only extends a held sequence gives none. The
// single front-of-buffer decode step resolves one sequence per cycle while
// the output register is empty or its word is being taken. No byte is taken
// while results of the previous one are still being produced; a result word
// waiting at the output does not block the next byte. Malformed sequences
// give '?' (0x3F) with replaced set, and string_ok on the final word tells
// whether the whole string decoded cleanly.
module utf8_to_utf32_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utf8d_in_if.sink    i_in,
    utf8d_out_if.source o_out
);

    utf8d_pkg::t_cmd    cmd;
    utf8d_pkg::t_status status;

    utf8d_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    utf8d_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_data_byte   (i_in.data_byte),
        .i_string_end  (i_in.string_end),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_code_point  (o_out.code_point),
        .o_replaced    (o_out.replaced),
        .o_burst_last  (o_out.burst_last),
        .o_string_last (o_out.string_last),
        .o_string_ok   (o_out.string_ok)
    );

endmodule

[rtl/core/utf8d_checker.sv]
// ----------------------------------------------------------------------------
// utf8d_checker: port-level checks of the UTF-8 decoder
// Output handshake rules and consistency of the result word flags.
// ----------------------------------------------------------------------------
module utf8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_code_point,
    input logic        i_replaced,
    input logic        i_burst_last,
    input logic        i_string_last,
    input logic        i_string_ok
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_code_point) && $stable(i_replaced)
            && $stable(i_string_last))
        else $error("output word changed while stalled");

    a_repl_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_replaced |-> i_code_point == 21'h3F && !i_string_ok)
        else $error("replacement word is not a clean question mark");

    a_ok_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_string_ok |-> i_string_last)
        else $error("string_ok outside the final word");

    a_last_nest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_string_last |-> i_burst_last)
        else $error("string end word is not the end of its burst");

endmodule

bind utf8_to_utf32_decoder utf8d_checker u_utf8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_code_point  (o_out.code_point),
    .i_replaced    (o_out.replaced),
    .i_burst_last  (o_out.burst_last),
    .i_string_last (o_out.string_last),
    .i_string_ok   (o_out.string_ok)
);

[dv/utf8_to_utf32_decoder_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder_checker: scoreboard of the UTF-8 decoder
// Watches the byte and code point channels. Each accepted byte is run through
// a local UTF-8 decoder, which queues the code point words the block must
// give. Each accepted output word is compared against the oldest queued word.
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utf8d_in_if         i_in_ch,
    utf8d_out_if        i_out_ch,
    output int unsigned o_fail_cnt,
    output int unsigned o_pending,
    output int unsigned o_bytes,
    output int unsigned o_strings,
    output int unsigned o_words,
    output int unsigned o_replaced
);

    typedef struct packed {
        logic [utf8d_pkg::CP_W-1:0] code_point;
        logic                       replaced;
        logic                       burst_last;
        logic                       string_last;
        logic                       string_ok;
    } t_cp_word;

    t_cp_word                     cp_expected_q[$];
    logic [utf8d_pkg::BYTE_W-1:0] held[utf8d_pkg::DEPTH];
    int unsigned                  held_cnt;
    logic                         str_clean;

    function automatic int unsigned utf8_span(input logic [utf8d_pkg::BYTE_W-1:0] c0);
        casez (c0)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    function automatic string word_str(input t_cp_word w);
        return $sformatf("cp=%06h repl=%b burst_last=%b str_last=%b str_ok=%b",
                         w.code_point, w.replaced, w.burst_last, w.string_last,
                         w.string_ok);
    endfunction

    task automatic discard_held(input int unsigned cnt);
        if (cnt >= held_cnt) begin
            held_cnt = 0;
        end else begin
            for (int unsigned i = 0; i < held_cnt - cnt; i++) begin
                held[i] = held[i + cnt];
            end
            held_cnt -= cnt;
        end
    endtask

    task automatic decode_byte(input logic [utf8d_pkg::BYTE_W-1:0] b, input logic last);
        t_cp_word                   res[4];
        int unsigned                n;
        int unsigned                span;
        int unsigned                take;
        logic                       emit;
        logic                       bad;
        logic                       conts_ok;
        logic                       stalled;
        logic [utf8d_pkg::CP_W-1:0] cp;
        logic [utf8d_pkg::CP_W-1:0] dec;
        n = 0;
        stalled = 1'b0;
        if (held_cnt > 3) begin
            held_cnt = 3;
        end
        held[held_cnt] = b;
        held_cnt++;
        while (held_cnt > 0 && n < 4 && !stalled) begin
            span = utf8_span(held[0]);
            emit = 1'b1;
            bad  = 1'b1;
            cp   = utf8d_pkg::REPL_CHAR;
            take = 1;
            if (span == 0) begin
                // bad lead or stray continuation: drop one byte
            end else if (held_cnt < span) begin
                // sequence still open; end of string truncates it
                stalled = 1'b1;
                emit    = last;
                take    = last ? held_cnt : 0;
            end else begin
                conts_ok = 1'b1;
                for (int unsigned i = 1; i < span; i++) begin
                    if (held[i][7:6] != 2'b10) begin
                        conts_ok = 1'b0;
                    end
                end
                if (conts_ok) begin
                    take = span;
                    case (span)
                        1: begin
                            dec = {13'd0, held[0]};
                            bad = 1'b0;
                        end
                        2: begin
                            dec = {10'd0, held[0][4:0], held[1][5:0]};
                            bad = dec < utf8d_pkg::MIN_2B;
                        end
                        3: begin
                            dec = {5'd0, held[0][3:0], held[1][5:0], held[2][5:0]};
                            bad = dec < utf8d_pkg::MIN_3B;
                        end
                        default: begin
                            dec = {held[0][2:0], held[1][5:0], held[2][5:0], held[3][5:0]};
                            bad = dec < utf8d_pkg::MIN_4B || dec > utf8d_pkg::MAX_CP;
                        end
                    endcase
                    if (!bad) begin
                        cp = dec;
                    end
                end
            end
            if (emit) begin
                res[n] = '{code_point: cp, replaced: bad, default: 1'b0};
                n++;
                if (bad) begin
                    str_clean = 1'b0;
                end
            end
            discard_held(take);
        end
        if (n > 0) begin
            res[n-1].burst_last = 1'b1;
            if (last) begin
                res[n-1].string_last = 1'b1;
                res[n-1].string_ok   = str_clean;
            end
        end
        if (last) begin
            held_cnt  = 0;
            str_clean = 1'b1;
        end
        for (int unsigned i = 0; i < n; i++) begin
            cp_expected_q.insert(cp_expected_q.size(), res[i]);
        end
    endtask

    always @(posedge i_clk) begin
        t_cp_word got;
        t_cp_word exp;
        if (!i_rst_n) begin
            cp_expected_q.delete();
            for (int i = 0; i < utf8d_pkg::DEPTH; i++) begin
                held[i] = '0;
            end
            held_cnt   = 0;
            str_clean  = 1'b1;
            o_fail_cnt = 0;
            o_pending  = 0;
            o_bytes    = 0;
            o_strings  = 0;
            o_words    = 0;
            o_replaced = 0;
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                decode_byte(i_in_ch.data_byte, i_in_ch.string_end);
                o_bytes++;
                if (i_in_ch.string_end) begin
                    o_strings++;
                end
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                got = '{i_out_ch.code_point, i_out_ch.replaced, i_out_ch.burst_last,
                        i_out_ch.string_last, i_out_ch.string_ok};
                o_words++;
                if (got.replaced) begin
                    o_replaced++;
                end
                if (cp_expected_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %s",
                             $time, word_str(got));
                    o_fail_cnt++;
                end else begin
                    exp = cp_expected_q.pop_front();
                    if (got !== exp) begin
                        $display("%0t: mismatch, expected %s, got %s",
                                 $time, word_str(exp), word_str(got));
                        o_fail_cnt++;
                    end
                end
            end
            o_pending = cp_expected_q.size();
        end
    end

endmodule

[dv/utf8_to_utf32_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder_tb: testbench top of the UTF-8 decoder
// Drives byte strings into the decoder: a directed set of boundary, overlong,
// out-of-range, broken and truncated sequences, then random strings that are
// mostly well-formed UTF-8 with malformed pieces mixed in. Both sides idle at
// random; a checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder_tb;

    localparam int unsigned RANDOM_BYTES = 330;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SLOW
    } t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        long_hold;
    int unsigned burst_left;
    int unsigned cycle_cnt;

    int unsigned fail_cnt;
    int unsigned pending;
    int unsigned byte_cnt;
    int unsigned string_cnt;
    int unsigned word_cnt;
    int unsigned replaced_cnt;

    utf8d_in_if  in_ch ();
    utf8d_out_if out_ch ();

    utf8_to_utf32_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    utf8_to_utf32_decoder_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .i_out_ch   (out_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_bytes    (byte_cnt),
        .o_strings  (string_cnt),
        .o_words    (word_cnt),
        .o_replaced (replaced_cnt)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        cycle_cnt = 0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // output side: random stall patterns, plus one long hold-off on request
    initial begin : rx
        t_rx_mode    mode;
        int unsigned mode_left;
        int unsigned hold_left;
        bit          hold_done;
        out_ch.ready = 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   out_ch.ready <= 1'b1;
                    RX_RANDOM: out_ch.ready <= $urandom_range(0, 1);
                    default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last_b);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.string_end <= last_b;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_string(input logic [7:0] s[$]);
        foreach (s[i]) begin
            send_word(s[i], i == s.size() - 1);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic [utf8d_pkg::CP_W-1:0] rand_cp(input int unsigned nb);
        case (nb)
            1: return 21'($urandom_range(0, 'h7F));
            2: return 21'($urandom_range('h80, 'h7FF));
            3: return 21'(($urandom_range(0, 7) == 0) ? $urandom_range('hD800, 'hDFFF)
                                                      : $urandom_range('h800, 'hFFFF));
            default: return 21'($urandom_range('h10000, 'h10FFFF));
        endcase
    endfunction

    // encode cp in nb bytes, overlong if cp is small enough for fewer
    task automatic put_cp(ref logic [7:0] q[$], input logic [utf8d_pkg::CP_W-1:0] cp,
                          input int unsigned nb);
        case (nb)
            1: q.insert(q.size(), cp[7:0]);
            2: begin
                q.insert(q.size(), {3'b110, cp[10:6]});
                q.insert(q.size(), {2'b10, cp[5:0]});
            end
            3: begin
                q.insert(q.size(), {4'b1110, cp[15:12]});
                q.insert(q.size(), {2'b10, cp[11:6]});
                q.insert(q.size(), {2'b10, cp[5:0]});
            end
            default: begin
                q.insert(q.size(), {5'b11110, cp[20:18]});
                q.insert(q.size(), {2'b10, cp[17:12]});
                q.insert(q.size(), {2'b10, cp[11:6]});
                q.insert(q.size(), {2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_char(ref logic [7:0] q[$]);
        int unsigned pick;
        int unsigned nb;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        nb   = $urandom_range(2, 4);
        if (pick < 25) begin
            put_cp(q, rand_cp(1), 1);
        end else if (pick < 40) begin
            put_cp(q, rand_cp(2), 2);
        end else if (pick < 55) begin
            put_cp(q, rand_cp(3), 3);
        end else if (pick < 68) begin
            put_cp(q, rand_cp(4), 4);
        end else if (pick < 72) begin
            put_cp(q, rand_cp(nb - 1), nb);
        end else if (pick < 76) begin
            put_cp(q, 21'($urandom_range('h110000, 'h1FFFFF)), 4);
        end else if (pick < 81) begin
            put_cp(q, rand_cp(nb), nb);
            repeat ($urandom_range(1, nb - 1)) begin
                void'(q.pop_back());
            end
        end else if (pick < 86) begin
            put_cp(q, rand_cp(nb), nb);
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == 2'b10) begin
                b[6] = 1'b1;
            end
            q[q.size() - 1 - $urandom_range(0, nb - 2)] = b;
        end else if (pick < 90) begin
            q.insert(q.size(), {2'b10, 6'($urandom_range(0, 63))});
        end else if (pick < 94) begin
            q.insert(q.size(), 8'hF8 + 8'($urandom_range(0, 7)));
        end else begin
            q.insert(q.size(), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stim
        logic [7:0]  str[$];
        int unsigned rand_bytes;
        int unsigned nchars;
        bit          mid_drained;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.string_end = 1'b0;
        i_rst_n          = 1'b0;
        long_hold        = 1'b0;
        burst_left       = 0;
        rand_bytes       = 0;
        mid_drained      = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // NUL, literal '?', overlong 2-byte
        str = {8'h00, 8'h3F, 8'hC1, 8'h80};
        send_string(str);
        // max 2-byte, surrogate passthrough, overlong 3-byte
        str = {8'hDF, 8'hBF, 8'hED, 8'hBF, 8'hBF, 8'hE0, 8'h80, 8'h80};
        send_string(str);
        // max code point, just above it
        str = {8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h90, 8'h80, 8'h80};
        send_string(str);
        // stray continuation, bad lead
        str = {8'h80, 8'hFF};
        send_string(str);
        // 4-byte lead broken by ASCII (four words from one byte), then truncation
        str = {8'hF0, 8'h41, 8'h42, 8'h43, 8'hC3};
        send_string(str);
        drain();

        while (rand_bytes < RANDOM_BYTES) begin
            str.delete();
            nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                                 : $urandom_range(1, 8);
            repeat (nchars) add_char(str);
            if (!long_hold && rand_bytes >= 120) begin
                long_hold <= 1'b1;
            end
            if (!mid_drained && rand_bytes >= 240) begin
                drain();
                mid_drained = 1'b1;
            end
            send_string(str);
            rand_bytes += str.size();
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d strings; %0d code point words back, %0d replaced.",
                 byte_cnt, string_cnt, word_cnt, replaced_cnt);
        $display("Covered burst input, random output stalls, a long output hold-off "
                 , "and drain pauses.");
        if (fail_cnt == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
